@@ src/u8dec_pkg.sv @@
package u8dec_pkg;

  localparam int unsigned CpW  = 31;
  localparam int unsigned LenW = 3;

  // Sequence lengths; zero means no sequence is open.
  localparam logic [LenW-1:0] LenNone = 3'd0;
  localparam logic [LenW-1:0] LenOne  = 3'd1;
  localparam logic [LenW-1:0] LenTwo  = 3'd2;
  localparam logic [LenW-1:0] LenThr  = 3'd3;
  localparam logic [LenW-1:0] LenFour = 3'd4;
  localparam logic [LenW-1:0] LenFive = 3'd5;
  localparam logic [LenW-1:0] LenSix  = 3'd6;

  localparam logic [7:0] ContMask = 8'hc0;
  localparam logic [7:0] ContTag  = 8'h80;
  localparam logic [7:0] PayMask  = 8'h3f;

  typedef struct packed {
    logic [LenW-1:0] len;   // LenNone for an invalid lead byte
    logic [6:0]      bits;  // payload bits of the lead byte
  } lead_t;

  function automatic lead_t lead_decode(input logic [7:0] b);
    lead_t r;
    r.len  = LenNone;
    r.bits = 7'd0;
    if (b[7] == 1'b0) begin
      r.len  = LenOne;
      r.bits = b[6:0];
    end else if (b[7:5] == 3'b110) begin
      r.len  = LenTwo;
      r.bits = {2'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      r.len  = LenThr;
      r.bits = {3'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      r.len  = LenFour;
      r.bits = {4'd0, b[2:0]};
    end else if (b[7:2] == 6'b111110) begin
      r.len  = LenFive;
      r.bits = {5'd0, b[1:0]};
    end else if (b[7:1] == 7'b1111110) begin
      r.len  = LenSix;
      r.bits = {6'd0, b[0]};
    end
    return r;
  endfunction

  function automatic logic [CpW-1:0] range_low(input logic [LenW-1:0] n);
    logic [CpW-1:0] r;
    case (n)
      LenTwo:  r = 31'h0000_0080;
      LenThr:  r = 31'h0000_0800;
      LenFour: r = 31'h0001_0000;
      LenFive: r = 31'h0020_0000;
      LenSix:  r = 31'h0400_0000;
      default: r = 31'h0000_0000;
    endcase
    return r;
  endfunction

  function automatic logic [CpW-1:0] range_high(input logic [LenW-1:0] n);
    logic [CpW-1:0] r;
    case (n)
      LenOne:  r = 31'h0000_007f;
      LenTwo:  r = 31'h0000_07ff;
      LenThr:  r = 31'h0000_ffff;
      LenFour: r = 31'h001f_ffff;
      LenFive: r = 31'h03ff_ffff;
      LenSix:  r = 31'h7fff_ffff;
      default: r = 31'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

@@ src/utf8_stream_decoder_core.sv @@
// An accepted byte goes first to the input register and then, if it yields a result,
// that result goes to the result register, which drives the outputs.
// Throughput: one byte per cycle while out_ready stays high. A waiting result holds the
// byte in the input register, and once that register is full in_ready stays low.
// Reset (rst_n low, synchronous): no sequence is open and both registers are empty.
module utf8_stream_decoder_core
  import u8dec_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_data_byte,
  input  logic            in_end_of_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CpW-1:0]  out_code_point,
  output logic            out_valid_res,
  output logic [LenW-1:0] out_byte_count
);

  // Input register: one byte and its end-of-data flag.
  logic            in_vld_r, in_vld_nxt;
  logic [7:0]      byte_r;
  logic            eod_r;

  // Sequence state.
  logic [CpW-1:0]  acc_r, acc_nxt;
  logic [LenW-1:0] exp_len_r, exp_len_nxt;
  logic [LenW-1:0] seen_r, seen_nxt;
  logic            err_r, err_nxt;

  // Result register.
  logic            out_vld_r, out_vld_nxt;
  logic [CpW-1:0]  cp_r, cp_nxt;
  logic            ok_r, ok_nxt;
  logic [LenW-1:0] cnt_r, cnt_nxt;

  logic            advance;   // the held byte is decoded this cycle
  logic            emit;      // the decoded byte closes a sequence
  lead_t           lead;
  logic [CpW-1:0]  acc_shift;
  logic [LenW-1:0] seen_inc;
  logic            bad_cont;

  // The held byte moves on when the result register is free or is being emptied.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;
  assign in_vld_nxt = (in_valid && in_ready) || (in_vld_r && !advance);

  assign lead      = lead_decode(byte_r);
  assign acc_shift = {acc_r[CpW-7:0], byte_r[5:0] & PayMask[5:0]};
  assign seen_inc  = seen_r + LenOne;
  assign bad_cont  = (byte_r & ContMask) != ContTag;

  always_comb begin
    acc_nxt     = acc_r;
    exp_len_nxt = exp_len_r;
    seen_nxt    = seen_r;
    err_nxt     = err_r;
    emit        = 1'b0;
    cp_nxt      = '0;
    ok_nxt      = 1'b0;
    cnt_nxt     = LenOne;
    if (advance) begin
      if (exp_len_r == LenNone) begin
        // Lead byte: either a result at once, or a new sequence opens.
        if (lead.len == LenOne) begin
          emit   = 1'b1;
          ok_nxt = 1'b1;
          cp_nxt = {{(CpW-7){1'b0}}, lead.bits};
        end else if (lead.len == LenNone || eod_r) begin
          emit = 1'b1;
        end else begin
          acc_nxt     = {{(CpW-7){1'b0}}, lead.bits};
          exp_len_nxt = lead.len;
          seen_nxt    = LenOne;
          err_nxt     = 1'b0;
        end
      end else begin
        // Continuation byte: always consumed, whatever its value.
        if (seen_inc >= exp_len_r) begin
          emit    = 1'b1;
          cnt_nxt = exp_len_r;
          ok_nxt  = !err_r && !bad_cont &&
                    acc_shift >= range_low(exp_len_r) &&
                    acc_shift <= range_high(exp_len_r);
          cp_nxt  = ok_nxt ? acc_shift : '0;
          acc_nxt     = '0;
          exp_len_nxt = LenNone;
          seen_nxt    = LenNone;
          err_nxt     = 1'b0;
        end else if (eod_r) begin
          // End of data cuts the sequence short.
          emit        = 1'b1;
          cnt_nxt     = seen_inc;
          acc_nxt     = '0;
          exp_len_nxt = LenNone;
          seen_nxt    = LenNone;
          err_nxt     = 1'b0;
        end else begin
          acc_nxt  = acc_shift;
          seen_nxt = seen_inc;
          err_nxt  = err_r || bad_cont;
        end
      end
    end
  end

  assign out_vld_nxt = emit || (out_vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      acc_r     <= '0;
      exp_len_r <= LenNone;
      seen_r    <= LenNone;
      err_r     <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      acc_r     <= acc_nxt;
      exp_len_r <= exp_len_nxt;
      seen_r    <= seen_nxt;
      err_r     <= err_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
      eod_r  <= in_end_of_data;
    end
    if (emit) begin
      cp_r  <= cp_nxt;
      ok_r  <= ok_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_code_point = cp_r;
  assign out_valid_res  = ok_r;
  assign out_byte_count = cnt_r;

  // An invalid result always carries a zero code point.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !ok_r |-> cp_r == '0)
    else $error("invalid result with nonzero code point");

  // Byte count of a result stays within one to six.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> cnt_r != LenNone && cnt_r <= LenSix)
    else $error("result byte count out of range");

  // An open sequence has consumed fewer bytes than its length.
  a_seq_open: assert property (@(posedge clk) disable iff (!rst_n)
    exp_len_r != LenNone |-> seen_r != LenNone && seen_r < exp_len_r &&
                              exp_len_r != LenOne && exp_len_r <= LenSix)
    else $error("sequence state inconsistent");

  // A result never gets overwritten while it waits to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ready |-> !emit)
    else $error("result register overwritten");

endmodule
